FILE: hw/rtl/spi_pkg.sv
// Shared types and constants for the stroke point interpolator.
// Holds the beat payload structs and the controller to datapath command set.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spi_pkg;

  localparam int COORD_BITS    = 24;
  localparam int SPACING_BITS  = 23;
  localparam int MAG_BITS      = COORD_BITS + 1;
  localparam int Q4_BITS       = 2 * MAG_BITS + 3;
  localparam logic [SPACING_BITS-1:0] SPACING_RESET = 23'd3277;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_MOVE  = 2'd1;
  localparam logic [1:0] OP_HOVER = 2'd2;

  localparam logic [1:0] DIV_X_LIN  = 2'd0;
  localparam logic [1:0] DIV_X_QUAD = 2'd1;
  localparam logic [1:0] DIV_Y_LIN  = 2'd2;
  localparam logic [1:0] DIV_Y_QUAD = 2'd3;

  typedef struct packed {
    logic [1:0]                   op;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
  } spi_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last_of_run;
    logic                         count_clipped;
  } spi_out_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MAG,
    DP_SQX,
    DP_SQY,
    DP_SUM,
    DP_SRCH_INIT,
    DP_SRCH_STEP,
    DP_SETUP,
    DP_MUL,
    DP_DIV_START,
    DP_EMIT_INIT,
    DP_EMIT_STEP,
    DP_OUT,
    DP_COMMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] div_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_start;
    logic move_ok;
    logic srch_done;
    logic div_done;
    logic run_last;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spi_div.sv
// Bit-serial signed floor divider with a non-negative remainder.
// One quotient bit per cycle, then a sign fix step. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module spi_div #(
  parameter int NW = 35,
  parameter int DW = 14
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [NW-1:0] dividend_i,
  input  wire logic [DW-1:0]        divisor_i,
  output logic                      done_o,
  output logic signed [NW-1:0]      quo_o,
  output logic [DW-1:0]             rem_o
);

  localparam int CW = $clog2(NW + 1);

  logic          run_q, fix_q, done_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q, den_q;
  logic [DW:0]   shifted;
  logic          fits;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign fits    = shifted >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(NW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          run_q <= 1'b0;
          fix_q <= 1'b1;
        end
      end else if (fix_q) begin
        fix_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[NW-1];
      quo_q <= dividend_i[NW-1] ? NW'(-dividend_i) : NW'(dividend_i);
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[NW-2:0], fits};
      rem_q <= fits ? DW'(shifted - {1'b0, den_q}) : shifted[DW-1:0];
    end else if (fix_q && neg_q) begin
      if (rem_q != '0) begin
        quo_q <= ~quo_q;
        rem_q <= den_q - rem_q;
      end else begin
        quo_q <= NW'(-quo_q);
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = $signed(quo_q);
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

FILE: hw/rtl/spi_dp.sv
// Datapath of the stroke point interpolator: history, count search and
// incremental point generation. Depends on spi_pkg and spi_div.
`timescale 1ns / 1ps
`default_nettype none

module spi_dp #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic [spi_pkg::SPACING_BITS-1:0]    spacing_i,
  input  wire spi_pkg::spi_in_t                    in_data_i,
  input  wire spi_pkg::dp_cmd_t                    cmd_i,
  output spi_pkg::dp_sts_t                         sts_o,
  output spi_pkg::spi_out_t                        out_data_o
);

  localparam int CW   = spi_pkg::COORD_BITS;
  localparam int MW   = spi_pkg::MAG_BITS;
  localparam int Q4W  = spi_pkg::Q4_BITS;
  localparam int AW   = CW + 1;
  localparam int BW   = CW + 3;
  localparam int KW   = $clog2(MAX_POINTS + 1);
  localparam int JW   = $clog2(MAX_POINTS + 2);
  localparam int DW   = $clog2(MAX_POINTS + 2);
  localparam int DENW = $clog2(2 * (MAX_POINTS + 1) * (MAX_POINTS + 1) + 1);
  localparam int WSW  = spi_pkg::SPACING_BITS + $clog2(2 * MAX_POINTS + 2);
  localparam int SQW  = 2 * WSW;
  localparam int PW   = AW + DW + 1;
  localparam int DIVW = PW + 1;
  localparam int SW   = DIVW + 1;
  localparam logic signed [SW-1:0] SAT_HI = {{(SW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

  spi_pkg::spi_in_t         in_q;
  logic signed [CW-1:0]     prev_x_q, prev_y_q, pp_x_q, pp_y_q, last_x_q, last_y_q;
  logic                     active_q;
  logic [MW-1:0]            ax_q, ay_q;
  logic signed [AW-1:0]     lin_x_q, lin_y_q;
  logic signed [BW-1:0]     quad_x_q, quad_y_q;
  logic [2*MW-1:0]          sqx_q, sqy_q;
  logic [Q4W-1:0]           q4_q;
  logic [WSW-1:0]           ws_q;
  logic [SQW-1:0]           sqr_q;
  logic [JW-1:0]            j_q, jp_q;
  logic                     pend_q, srch_done_q;
  logic [KW-1:0]            k_q, n_q, e_q;
  logic                     clip_q;
  logic [DW-1:0]            d_q;
  logic [2*DW-1:0]          dsq_q;
  logic signed [PW-1:0]     prod_q;
  logic signed [DIVW-1:0]   qx_q, qy_q, dqx_q, dqy_q, eqx_q, eqy_q;
  logic [DENW-1:0]          rx_q, ry_q, drx_q, dry_q, erx_q, ery_q;
  spi_pkg::spi_out_t        out_q;

  logic                     is_start, move_ok;
  logic signed [AW-1:0]     dx, dy;
  logic [DENW-1:0]          den;
  logic signed [PW-1:0]     a_ext, d_ext;
  logic signed [BW-1:0]     b_sel;
  logic signed [DIVW-1:0]   div_lin, div_quad, dividend;
  logic                     div_start, div_done;
  logic signed [DIVW-1:0]   div_quo;
  logic [DENW-1:0]          div_rem;
  logic [DIVW+DENW-1:0]     stx, sty, sdx, sdy;
  logic                     sqr_fits;

  function automatic logic [DIVW+DENW-1:0] acc_step(
    input logic signed [DIVW-1:0] q,
    input logic [DENW-1:0]        r,
    input logic signed [DIVW-1:0] dq,
    input logic [DENW-1:0]        dr,
    input logic [DENW-1:0]        dn
  );
    logic [DENW:0]          rs;
    logic signed [DIVW-1:0] qn;
    logic [DENW-1:0]        rn;
    rs = {1'b0, r} + {1'b0, dr};
    if (rs >= {1'b0, dn}) begin
      rn = DENW'(rs - {1'b0, dn});
      qn = q + dq + DIVW'(1);
    end else begin
      rn = rs[DENW-1:0];
      qn = q + dq;
    end
    return {qn, rn};
  endfunction

  function automatic logic signed [CW-1:0] sat_c(
    input logic signed [CW-1:0]   p,
    input logic signed [DIVW-1:0] q
  );
    logic signed [SW-1:0] v;
    v = SW'(p) + SW'(q);
    if (v > SAT_HI) begin
      return SAT_HI[CW-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  assign is_start = in_q.op == spi_pkg::OP_START;
  assign move_ok  = (in_q.op == spi_pkg::OP_MOVE) && active_q &&
                    !((in_q.pos_x == last_x_q) && (in_q.pos_y == last_y_q)) &&
                    !((in_q.pos_x == prev_x_q) && (in_q.pos_y == prev_y_q));

  assign dx = {in_q.pos_x[CW-1], in_q.pos_x} - {prev_x_q[CW-1], prev_x_q};
  assign dy = {in_q.pos_y[CW-1], in_q.pos_y} - {prev_y_q[CW-1], prev_y_q};

  assign den      = DENW'({dsq_q, 1'b0});
  assign a_ext    = cmd_i.div_sel[1] ? PW'(lin_y_q) : PW'(lin_x_q);
  assign d_ext    = PW'($signed({1'b0, d_q}));
  assign b_sel    = cmd_i.div_sel[1] ? quad_y_q : quad_x_q;
  assign div_lin  = DIVW'(prod_q) + DIVW'(b_sel);
  assign div_quad = DIVW'($signed({b_sel, 1'b0}));
  assign dividend = cmd_i.div_sel[0] ? div_quad : div_lin;
  assign div_start = cmd_i.op == spi_pkg::DP_DIV_START;

  assign stx = acc_step(qx_q, rx_q, dqx_q, drx_q, den);
  assign sty = acc_step(qy_q, ry_q, dqy_q, dry_q, den);
  assign sdx = acc_step(dqx_q, drx_q, eqx_q, erx_q, den);
  assign sdy = acc_step(dqy_q, dry_q, eqy_q, ery_q, den);

  assign sqr_fits = sqr_q <= q4_q;

  spi_div #(
    .NW(DIVW),
    .DW(DENW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (den),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      pp_x_q      <= '0;
      pp_y_q      <= '0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      active_q    <= 1'b0;
      pend_q      <= 1'b0;
      srch_done_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        spi_pkg::DP_SRCH_INIT: begin
          pend_q      <= 1'b0;
          srch_done_q <= 1'b0;
        end
        spi_pkg::DP_SRCH_STEP: begin
          if (!srch_done_q) begin
            if (pend_q && (!sqr_fits || (jp_q == JW'(MAX_POINTS)))) begin
              pend_q      <= 1'b0;
              srch_done_q <= 1'b1;
            end else begin
              pend_q <= 1'b1;
            end
          end
        end
        spi_pkg::DP_COMMIT: begin
          if (is_start) begin
            prev_x_q <= in_q.pos_x;
            prev_y_q <= in_q.pos_y;
            pp_x_q   <= in_q.pos_x;
            pp_y_q   <= in_q.pos_y;
            active_q <= 1'b1;
          end else if (move_ok) begin
            pp_x_q   <= prev_x_q;
            pp_y_q   <= prev_y_q;
            prev_x_q <= in_q.pos_x;
            prev_y_q <= in_q.pos_y;
          end
          last_x_q <= in_q.pos_x;
          last_y_q <= in_q.pos_y;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      case (cmd_i.div_sel)
        spi_pkg::DIV_X_LIN: begin
          dqx_q <= div_quo;
          drx_q <= div_rem;
        end
        spi_pkg::DIV_X_QUAD: begin
          eqx_q <= div_quo;
          erx_q <= div_rem;
        end
        spi_pkg::DIV_Y_LIN: begin
          dqy_q <= div_quo;
          dry_q <= div_rem;
        end
        default: begin
          eqy_q <= div_quo;
          ery_q <= div_rem;
        end
      endcase
    end
    case (cmd_i.op)
      spi_pkg::DP_LOAD: begin
        in_q <= in_data_i;
      end
      spi_pkg::DP_MAG: begin
        ax_q     <= dx[AW-1] ? MW'(-dx) : MW'(dx);
        ay_q     <= dy[AW-1] ? MW'(-dy) : MW'(dy);
        lin_x_q  <= {in_q.pos_x[CW-1], in_q.pos_x} - {pp_x_q[CW-1], pp_x_q};
        lin_y_q  <= {in_q.pos_y[CW-1], in_q.pos_y} - {pp_y_q[CW-1], pp_y_q};
        quad_x_q <= {{3{in_q.pos_x[CW-1]}}, in_q.pos_x}
                  - {{2{prev_x_q[CW-1]}}, prev_x_q, 1'b0}
                  + {{3{pp_x_q[CW-1]}}, pp_x_q};
        quad_y_q <= {{3{in_q.pos_y[CW-1]}}, in_q.pos_y}
                  - {{2{prev_y_q[CW-1]}}, prev_y_q, 1'b0}
                  + {{3{pp_y_q[CW-1]}}, pp_y_q};
      end
      spi_pkg::DP_SQX: begin
        sqx_q <= ax_q * ax_q;
      end
      spi_pkg::DP_SQY: begin
        sqy_q <= ay_q * ay_q;
      end
      spi_pkg::DP_SUM: begin
        q4_q <= {({1'b0, sqx_q} + {1'b0, sqy_q}), 2'b00};
      end
      spi_pkg::DP_SRCH_INIT: begin
        ws_q <= WSW'(spacing_i);
        j_q  <= JW'(1);
        k_q  <= '0;
      end
      spi_pkg::DP_SRCH_STEP: begin
        if (!srch_done_q) begin
          if (pend_q && sqr_fits) begin
            k_q <= KW'(jp_q);
          end
          sqr_q <= ws_q * ws_q;
          jp_q  <= j_q;
          j_q   <= j_q + JW'(1);
          ws_q  <= ws_q + WSW'({spacing_i, 1'b0});
        end
      end
      spi_pkg::DP_SETUP: begin
        if (k_q == KW'(MAX_POINTS)) begin
          n_q    <= KW'(MAX_POINTS);
          d_q    <= DW'(MAX_POINTS + 1);
          clip_q <= 1'b1;
        end else begin
          n_q    <= k_q + KW'(1);
          d_q    <= DW'(k_q) + DW'(2);
          clip_q <= 1'b0;
        end
      end
      spi_pkg::DP_MUL: begin
        prod_q <= a_ext * d_ext;
        dsq_q  <= d_q * d_q;
      end
      spi_pkg::DP_EMIT_INIT: begin
        qx_q <= '0;
        qy_q <= '0;
        rx_q <= DENW'(dsq_q);
        ry_q <= DENW'(dsq_q);
        e_q  <= '0;
      end
      spi_pkg::DP_EMIT_STEP: begin
        qx_q  <= $signed(stx[DIVW+DENW-1:DENW]);
        rx_q  <= stx[DENW-1:0];
        qy_q  <= $signed(sty[DIVW+DENW-1:DENW]);
        ry_q  <= sty[DENW-1:0];
        dqx_q <= $signed(sdx[DIVW+DENW-1:DENW]);
        drx_q <= sdx[DENW-1:0];
        dqy_q <= $signed(sdy[DIVW+DENW-1:DENW]);
        dry_q <= sdy[DENW-1:0];
        e_q   <= e_q + KW'(1);
      end
      spi_pkg::DP_OUT: begin
        if (is_start) begin
          out_q.point_x       <= in_q.pos_x;
          out_q.point_y       <= in_q.pos_y;
          out_q.last_of_run   <= 1'b1;
          out_q.count_clipped <= 1'b0;
        end else begin
          out_q.point_x       <= sat_c(prev_x_q, qx_q);
          out_q.point_y       <= sat_c(prev_y_q, qy_q);
          out_q.last_of_run   <= e_q == n_q;
          out_q.count_clipped <= clip_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts_o.is_start  = is_start;
  assign sts_o.move_ok   = move_ok;
  assign sts_o.srch_done = srch_done_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.run_last  = e_q == n_q;
  assign out_data_o      = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/spi_ctrl.sv
// Sequencer of the stroke point interpolator: steps the datapath through
// one item and owns the beat handshakes. Depends on spi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spi_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire spi_pkg::dp_sts_t sts_i,
  output spi_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_MAG,
    S_SQX,
    S_SQY,
    S_SUM,
    S_SINIT,
    S_SRCH,
    S_SETUP,
    S_MUL,
    S_DIV,
    S_DWAIT,
    S_EINIT,
    S_STEP,
    S_OUT,
    S_COMMIT
  } state_e;

  state_e     state_q;
  logic [1:0] sel_q;
  logic       out_valid_q;
  logic       slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.div_sel = sel_q;
    case (state_q)
      S_IDLE:   cmd_o.op = in_valid_i ? spi_pkg::DP_LOAD : spi_pkg::DP_NOP;
      S_MAG:    cmd_o.op = spi_pkg::DP_MAG;
      S_SQX:    cmd_o.op = spi_pkg::DP_SQX;
      S_SQY:    cmd_o.op = spi_pkg::DP_SQY;
      S_SUM:    cmd_o.op = spi_pkg::DP_SUM;
      S_SINIT:  cmd_o.op = spi_pkg::DP_SRCH_INIT;
      S_SRCH:   cmd_o.op = spi_pkg::DP_SRCH_STEP;
      S_SETUP:  cmd_o.op = spi_pkg::DP_SETUP;
      S_MUL:    cmd_o.op = spi_pkg::DP_MUL;
      S_DIV:    cmd_o.op = spi_pkg::DP_DIV_START;
      S_EINIT:  cmd_o.op = spi_pkg::DP_EMIT_INIT;
      S_STEP:   cmd_o.op = spi_pkg::DP_EMIT_STEP;
      S_OUT:    cmd_o.op = slot_free ? spi_pkg::DP_OUT : spi_pkg::DP_NOP;
      S_COMMIT: cmd_o.op = spi_pkg::DP_COMMIT;
      default:  cmd_o.op = spi_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= spi_pkg::DIV_X_LIN;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (sts_i.is_start) begin
            state_q <= S_OUT;
          end else if (sts_i.move_ok) begin
            state_q <= S_MAG;
          end else begin
            state_q <= S_COMMIT;
          end
        end
        S_MAG:   state_q <= S_SQX;
        S_SQX:   state_q <= S_SQY;
        S_SQY:   state_q <= S_SUM;
        S_SUM:   state_q <= S_SINIT;
        S_SINIT: state_q <= S_SRCH;
        S_SRCH: begin
          if (sts_i.srch_done) begin
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          sel_q   <= spi_pkg::DIV_X_LIN;
          state_q <= S_MUL;
        end
        S_MUL: state_q <= S_DIV;
        S_DIV: state_q <= S_DWAIT;
        S_DWAIT: begin
          if (sts_i.div_done) begin
            if (sel_q == spi_pkg::DIV_Y_QUAD) begin
              state_q <= S_EINIT;
            end else begin
              sel_q   <= sel_q + 2'd1;
              state_q <= (sel_q == spi_pkg::DIV_X_QUAD) ? S_MUL : S_DIV;
            end
          end
        end
        S_EINIT: state_q <= S_STEP;
        S_STEP:  state_q <= S_OUT;
        S_OUT: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            state_q     <= (sts_i.is_start || sts_i.run_last) ? S_COMMIT : S_STEP;
          end
        end
        S_COMMIT: state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/stroke_point_interpolator_core.sv
// Stroke start: the point is offered once its beat is decided, and the item is then
// committed; hover and ignored moves are committed without output. A drawing move
// runs magnitudes, the count search and four serial divisions (DIVW = 34 at 64
// points), then an emit step and an output per point; one item is in flight.
// Asynchronous active-low reset clears history, stroke flag and handshakes and sets
// the point spacing to 3277. Depends on spi_pkg, spi_ctrl and spi_dp.
`timescale 1ns / 1ps
`default_nettype none

module stroke_point_interpolator_core #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [spi_pkg::SPACING_BITS-1:0] cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire spi_pkg::spi_in_t                 in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output spi_pkg::spi_out_t                     out_data_o
);

  logic [spi_pkg::SPACING_BITS-1:0] spacing_q;
  spi_pkg::dp_cmd_t                 cmd;
  spi_pkg::dp_sts_t                 sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= spi_pkg::SPACING_RESET;
    end else if (cfg_we_i) begin
      spacing_q <= cfg_wdata_i;
    end
  end

  spi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  spi_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .spacing_i  (spacing_q),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

FILE: bench/spi_checker.sv
// Checker for the stroke point interpolator: watches the configuration port and both
// beat channels, predicts the stroke points of every accepted sample and compares them.
// Depends on spi_pkg.
`timescale 1ns / 1ps

module spi_checker #(
  parameter int MAX_POINTS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [spi_pkg::SPACING_BITS-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  spi_pkg::spi_in_t                 in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  spi_pkg::spi_out_t                out_data_i,
  output int                               pending_o,
  output int                               errors_o
);

  longint prev_x, prev_y, prev_prev_x, prev_prev_y, sample_x, sample_y;
  bit stroke_on;
  longint unsigned spacing;
  spi_pkg::spi_out_t expected_points[$];

  function automatic logic signed [spi_pkg::COORD_BITS-1:0] clamp_coord(longint v);
    longint hi;
    hi = (longint'(1) <<< (spi_pkg::COORD_BITS - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[spi_pkg::COORD_BITS-1:0];
  endfunction

  function automatic longint curve_coord(longint p, longint pp, longint m, longint k,
                                         longint n);
    longint d, num, den, q, r;
    d = n + 1;
    num = 2 * ((m - pp) * k * d + (m - 2 * p + pp) * k * k) + 2 * d * d;
    den = 4 * d * d;
    q = num / den;
    r = num % den;
    if (r != 0 && num < 0) q = q - 1;
    return p + q;
  endfunction

  task automatic predict_points(spi_pkg::spi_in_t beat);
    longint mx, my, dx, dy, k, n, j;
    longint unsigned q4, s2, w;
    bit clipped;
    spi_pkg::spi_out_t pt;
    mx = beat.pos_x;
    my = beat.pos_y;
    if (beat.op == spi_pkg::OP_START) begin
      prev_x = mx; prev_prev_x = mx;
      prev_y = my; prev_prev_y = my;
      stroke_on = 1'b1;
      pt.point_x = clamp_coord(mx);
      pt.point_y = clamp_coord(my);
      pt.last_of_run = 1'b1;
      pt.count_clipped = 1'b0;
      expected_points.push_back(pt);
    end else if (beat.op == spi_pkg::OP_MOVE && stroke_on &&
                 !(mx == sample_x && my == sample_y) && !(mx == prev_x && my == prev_y)) begin
      dx = mx - prev_x;
      dy = my - prev_y;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      k = 0;
      if (dx >= (longint'(1) <<< 29) || dy >= (longint'(1) <<< 29)) begin
        k = MAX_POINTS;
      end else begin
        q4 = 4 * (dx * dx + dy * dy);
        s2 = spacing * spacing;
        for (j = 1; j <= MAX_POINTS; j++) begin
          w = 2 * j - 1;
          if (w * w * s2 <= q4) k = j;
          else break;
        end
      end
      n = k + 1;
      clipped = 1'b0;
      if (n > MAX_POINTS) begin
        n = MAX_POINTS;
        clipped = 1'b1;
      end
      for (j = 1; j <= n; j++) begin
        pt.point_x = clamp_coord(curve_coord(prev_x, prev_prev_x, mx, j, n));
        pt.point_y = clamp_coord(curve_coord(prev_y, prev_prev_y, my, j, n));
        pt.last_of_run = (j == n);
        pt.count_clipped = clipped;
        expected_points.push_back(pt);
      end
      prev_prev_x = prev_x; prev_prev_y = prev_y;
      prev_x = mx; prev_y = my;
    end
    sample_x = mx;
    sample_y = my;
  endtask

  task automatic compare_point(spi_pkg::spi_out_t got);
    spi_pkg::spi_out_t want;
    if (expected_points.size() == 0) begin
      $error("unexpected point x=%0d y=%0d", got.point_x, got.point_y);
      errors_o++;
    end else begin
      want = expected_points.pop_front();
      if (got.point_x !== want.point_x) begin
        $error("point_x: expected %0d, actual %0d", want.point_x, got.point_x);
        errors_o++;
      end
      if (got.point_y !== want.point_y) begin
        $error("point_y: expected %0d, actual %0d", want.point_y, got.point_y);
        errors_o++;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0b, actual %0b", want.last_of_run, got.last_of_run);
        errors_o++;
      end
      if (got.count_clipped !== want.count_clipped) begin
        $error("count_clipped: expected %0b, actual %0b", want.count_clipped,
               got.count_clipped);
        errors_o++;
      end
    end
  endtask

  initial errors_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x = 0; prev_y = 0; prev_prev_x = 0; prev_prev_y = 0;
      sample_x = 0; sample_y = 0;
      stroke_on = 1'b0;
      spacing = spi_pkg::SPACING_RESET;
      expected_points.delete();
    end else begin
      if (out_valid_i && !out_stall_i) compare_point(out_data_i);
      if (cfg_we_i) spacing = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_points(in_data_i);
    end
    pending_o = expected_points.size();
  end

endmodule

FILE: bench/testbench.sv
// Top of the stroke point interpolator bench: clock, reset, sample stimulus, receiver
// stalls and the verdict. Depends on spi_pkg, spi_checker and stroke_point_interpolator_core.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [spi_pkg::SPACING_BITS-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  spi_pkg::spi_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  spi_pkg::spi_out_t out_data_o;
  int pending, errors;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int spacing_now = int'(spi_pkg::SPACING_RESET);
  int cur_x, cur_y, anchor_x, anchor_y;

  always #1 clk_i = ~clk_i;

  stroke_point_interpolator_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  spi_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_i(in_stall_o), .in_data_i(in_data_i),
    .out_valid_i(out_valid_o), .out_stall_i(out_stall_i), .out_data_i(out_data_o),
    .pending_o(pending), .errors_o(errors)
  );

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_sample(logic [1:0] op, int x, int y);
    logic signed [spi_pkg::COORD_BITS-1:0] px, py;
    px = spi_pkg::COORD_BITS'(x);
    py = spi_pkg::COORD_BITS'(y);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= '{op: op, pos_x: px, pos_y: py};
    do @(posedge clk_i); while (in_stall_o);
    if (op == spi_pkg::OP_START) begin
      anchor_x = px;
      anchor_y = py;
    end else if (op == spi_pkg::OP_MOVE) begin
      anchor_x = cur_x;
      anchor_y = cur_y;
    end
    cur_x = px;
    cur_y = py;
  endtask

  task automatic set_spacing(int value, int idle, int stall);
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= spi_pkg::SPACING_BITS'(value);
    @(negedge clk_i) cfg_we_i <= 1'b0;
    spacing_now = value;
    idle_pct = idle;
    stall_pct = stall;
  endtask

  task automatic random_samples(int count);
    int r, pick, span;
    span = (spacing_now == 0) ? 2000 : spacing_now * 6;
    if (span > 4000000 || span < 0) span = 4000000;
    repeat (count) begin
      pick = $urandom_range(99);
      r = $urandom_range(2 * span) - span;
      if (pick < 12)
        send_sample(spi_pkg::OP_START, $urandom, $urandom);
      else if (pick < 70)
        send_sample(spi_pkg::OP_MOVE, cur_x + r, cur_y + $urandom_range(2 * span) - span);
      else if (pick < 78)
        send_sample(spi_pkg::OP_HOVER, cur_x + r, cur_y - r);
      else if (pick < 82)
        send_sample(OP_SPARE, $urandom, $urandom);
      else if (pick < 87)
        send_sample(spi_pkg::OP_MOVE, cur_x, cur_y);
      else if (pick < 92)
        send_sample(spi_pkg::OP_MOVE, anchor_x, anchor_y);
      else
        send_sample(spi_pkg::OP_MOVE, $urandom, $urandom);
    end
  endtask

  initial begin
    cur_x = 0; cur_y = 0; anchor_x = 0; anchor_y = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    send_sample(spi_pkg::OP_MOVE, 100, 100);
    send_sample(spi_pkg::OP_START, 8388607, -8388608);
    send_sample(spi_pkg::OP_HOVER, 5, 5);
    send_sample(OP_SPARE, -5, 7);
    send_sample(spi_pkg::OP_START, 0, 0);
    send_sample(spi_pkg::OP_MOVE, 4096, 0);
    send_sample(spi_pkg::OP_MOVE, 4096, 0);
    send_sample(spi_pkg::OP_HOVER, 300, 300);
    send_sample(spi_pkg::OP_MOVE, 4096, 0);
    send_sample(spi_pkg::OP_MOVE, 8192, 2048);
    send_sample(spi_pkg::OP_MOVE, 7000, 9000);
    send_sample(spi_pkg::OP_START, -8388608, -8388608);
    send_sample(spi_pkg::OP_MOVE, 8388607, 8388607);
    send_sample(spi_pkg::OP_START, 0, 0);
    send_sample(spi_pkg::OP_MOVE, 8388607, 0);
    send_sample(spi_pkg::OP_MOVE, -8388608, 0);
    send_sample(spi_pkg::OP_MOVE, 8388607, -8388608);
    send_sample(spi_pkg::OP_MOVE, 0, 1);

    set_spacing(0, 0, 0);
    hold_left = 600;
    send_sample(spi_pkg::OP_START, 10, 20);
    random_samples(18);

    set_spacing(1, 75, 0);
    send_sample(spi_pkg::OP_START, -3, 3);
    random_samples(18);

    set_spacing(8388607, 0, 75);
    send_sample(spi_pkg::OP_START, 0, 0);
    send_sample(spi_pkg::OP_MOVE, 8388607, 8388607);
    random_samples(18);

    set_spacing($urandom_range(20000, 256), 14, 14);
    random_samples(18);

    set_spacing($urandom_range(8000, 1), 0, 0);
    random_samples(18);

    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("stroke_point_interpolator_core: match");
    end else begin
      $display("stroke_point_interpolator_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("stroke_point_interpolator_core: mismatch");
    $finish;
  end

endmodule
